// ===== rtl/chp_pkg.sv =====
`timescale 1ns / 1ps
package chp_pkg;

   typedef enum logic [4:0] {
      PH_PRE         = 5'd0,
      PH_SID_LEN     = 5'd1,
      PH_SID_BYTES   = 5'd2,
      PH_CS_LEN_HI   = 5'd3,
      PH_CS_LEN_LO   = 5'd4,
      PH_CS_HI       = 5'd5,
      PH_CS_LO       = 5'd6,
      PH_CMP_HI      = 5'd7,
      PH_CMP_LO      = 5'd8,
      PH_EXT_LEN_HI  = 5'd9,
      PH_EXT_LEN_LO  = 5'd10,
      PH_CODE_HI     = 5'd11,
      PH_CODE_LO     = 5'd12,
      PH_SIZE_HI     = 5'd13,
      PH_SIZE_LO     = 5'd14,
      PH_BODY_LEN_HI = 5'd15,
      PH_BODY_LEN_LO = 5'd16,
      PH_BODY_LEN1   = 5'd17,
      PH_SN_TYPE     = 5'd18,
      PH_SN_LEN_HI   = 5'd19,
      PH_SN_LEN_LO   = 5'd20,
      PH_BODY_BYTE   = 5'd21,
      PH_PAIR_HI     = 5'd22,
      PH_PAIR_LO     = 5'd23,
      PH_KS_GROUP_HI = 5'd24,
      PH_KS_GROUP_LO = 5'd25,
      PH_KS_KLEN_HI  = 5'd26,
      PH_KS_KLEN_LO  = 5'd27,
      PH_KS_KEY      = 5'd28,
      PH_KS_KEYSKIP  = 5'd29,
      PH_SKIP        = 5'd30
   } phase_type;

   localparam logic [3:0] KIND_SID     = 4'd0;
   localparam logic [3:0] KIND_CIPHER  = 4'd1;
   localparam logic [3:0] KIND_NAME    = 4'd2;
   localparam logic [3:0] KIND_GROUP   = 4'd3;
   localparam logic [3:0] KIND_SIGALG  = 4'd4;
   localparam logic [3:0] KIND_KSGROUP = 4'd5;
   localparam logic [3:0] KIND_PUBKEY  = 4'd6;
   localparam logic [3:0] KIND_PSK     = 4'd7;
   localparam logic [3:0] KIND_VERSION = 4'd8;
   localparam logic [3:0] KIND_END     = 4'd9;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_VERSION  = 3'd1;
   localparam logic [2:0] ST_COMPRESS = 3'd2;
   localparam logic [2:0] ST_LENGTH   = 3'd3;
   localparam logic [2:0] ST_UNKNOWN  = 3'd4;
   localparam logic [2:0] ST_TRUNC    = 3'd5;

   localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
   localparam logic [15:0] EXT_GROUPS      = 16'h000a;
   localparam logic [15:0] EXT_SIGALGS     = 16'h000d;
   localparam logic [15:0] EXT_VERSIONS    = 16'h002b;
   localparam logic [15:0] EXT_PSK_MODES   = 16'h002d;
   localparam logic [15:0] EXT_KEY_SHARE   = 16'h0033;

   localparam logic [15:0] LEGACY_VERSION   = 16'h0303;
   localparam logic [15:0] COMPRESSION_NULL = 16'h0100;
   localparam logic [15:0] HEADER_BYTES     = 16'd4;
   localparam logic [15:0] RANDOM_LAST      = 16'd37;

   // one entry of the queue between front and back
   typedef struct packed {
      logic        data_valid;
      logic [3:0]  kind;
      logic [15:0] value;
      logic [15:0] index;
      logic        end_valid;
      logic [2:0]  status;
   } event_type;

   typedef struct packed {
      logic [3:0]  item_kind;
      logic [15:0] item_value;
      logic [15:0] item_index;
      logic [2:0]  parse_status;
      logic        end_of_message;
   } rsp_type;

endpackage

// ===== rtl/chp_if.sv =====
`timescale 1ns / 1ps
interface chp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface chp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  item_kind;
   logic [15:0] item_value;
   logic [15:0] item_index;
   logic [2:0]  parse_status;
   logic        end_of_message;
   modport source (output valid, output item_kind, output item_value, output item_index,
                   output parse_status, output end_of_message, input ready);
   modport sink (input valid, input item_kind, input item_value, input item_index,
                 input parse_status, input end_of_message, output ready);
endinterface

// ===== rtl/chp_front.sv =====
`timescale 1ns / 1ps
module chp_front
   import chp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       q_ready,
   output logic       q_push,
   output event_type  q_event
);

   phase_type   phase_ff, phase_in;
   logic [15:0] msg_ff, msg_in;
   logic [15:0] ext_ff, ext_in;
   logic [15:0] fld_ff, fld_in;
   logic [15:0] ks_ff, ks_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] code_ff, code_in;
   logic [15:0] pos_ff, pos_in;
   logic        taken_ff, taken_in;
   logic        done_ff, done_in;
   logic [15:0] ileft_ff, ileft_in;
   logic        want_ff, want_in;

   logic        fire;
   logic [15:0] word;
   logic        known;

   assign in_ready = q_ready;
   assign fire     = in_valid && q_ready;
   assign word     = {hold_ff, in_byte};
   assign known    = (word == EXT_SERVER_NAME) || (word == EXT_GROUPS) ||
                     (word == EXT_SIGALGS) || (word == EXT_VERSIONS) ||
                     (word == EXT_PSK_MODES) || (word == EXT_KEY_SHARE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PRE;
         msg_ff   <= '0;
         ext_ff   <= '0;
         fld_ff   <= '0;
         ks_ff    <= '0;
         hold_ff  <= '0;
         code_ff  <= '0;
         pos_ff   <= '0;
         taken_ff <= 1'b0;
         done_ff  <= 1'b0;
         ileft_ff <= '0;
         want_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         msg_ff   <= msg_in;
         ext_ff   <= ext_in;
         fld_ff   <= fld_in;
         ks_ff    <= ks_in;
         hold_ff  <= hold_in;
         code_ff  <= code_in;
         pos_ff   <= pos_in;
         taken_ff <= taken_in;
         done_ff  <= done_in;
         ileft_ff <= ileft_in;
         want_ff  <= want_in;
      end
   end

   always_comb begin
      logic stop;
      logic fin;
      logic [2:0] fst;
      phase_in = phase_ff;
      msg_in   = msg_ff;
      ext_in   = ext_ff;
      fld_in   = fld_ff;
      ks_in    = ks_ff;
      hold_in  = hold_ff;
      code_in  = code_ff;
      pos_in   = pos_ff;
      taken_in = taken_ff;
      done_in  = done_ff;
      ileft_in = ileft_ff;
      want_in  = want_ff;
      q_event  = '0;
      stop     = 1'b0;
      fin      = 1'b0;
      fst      = ST_OK;

      if (!done_ff) begin
         if ((phase_ff != PH_PRE || pos_ff >= HEADER_BYTES) && msg_ff == 16'd0) begin
            fin  = 1'b1;
            fst  = ST_LENGTH;
            stop = 1'b1;
         end else begin
            if (phase_ff != PH_PRE || pos_ff >= HEADER_BYTES) msg_in = msg_ff - 16'd1;
            if (phase_ff >= PH_CODE_HI) ext_in = ext_ff - 16'd1;
            if (phase_ff >= PH_BODY_LEN_HI) fld_in = fld_ff - 16'd1;
            if (phase_ff >= PH_KS_GROUP_HI && phase_ff <= PH_KS_KEYSKIP) ks_in = ks_ff - 16'd1;

            case (phase_ff)
               PH_PRE: begin
                  if (pos_ff == 16'd2 || pos_ff == 16'd4) hold_in = in_byte;
                  else if (pos_ff == 16'd3) msg_in = word;
                  else if (pos_ff == 16'd5 && word != LEGACY_VERSION) begin
                     fin = 1'b1; fst = ST_VERSION; stop = 1'b1;
                  end
                  if (!stop) begin
                     if (pos_ff == RANDOM_LAST) phase_in = PH_SID_LEN;
                     pos_in = pos_ff + 16'd1;
                  end
               end
               PH_SID_LEN: begin
                  fld_in   = {8'd0, in_byte};
                  pos_in   = '0;
                  phase_in = (in_byte != 8'd0) ? PH_SID_BYTES : PH_CS_LEN_HI;
               end
               PH_SID_BYTES: begin
                  q_event.data_valid = 1'b1;
                  q_event.kind  = KIND_SID;
                  q_event.value = {8'd0, in_byte};
                  q_event.index = pos_ff;
                  pos_in = pos_ff + 16'd1;
                  fld_in = fld_ff - 16'd1;
                  if (fld_ff == 16'd1) phase_in = PH_CS_LEN_HI;
               end
               PH_CS_HI: begin
                  fld_in   = fld_ff - 16'd1;
                  hold_in  = in_byte;
                  phase_in = PH_CS_LO;
               end
               PH_CS_LO: begin
                  fld_in = fld_ff - 16'd1;
                  q_event.data_valid = 1'b1;
                  q_event.kind  = KIND_CIPHER;
                  q_event.value = word;
                  q_event.index = pos_ff;
                  pos_in   = pos_ff + 16'd1;
                  phase_in = (fld_ff != 16'd1) ? PH_CS_HI : PH_CMP_HI;
               end
               PH_CS_LEN_LO: begin
                  fld_in   = {word[15:1], 1'b0};
                  pos_in   = '0;
                  phase_in = (word[15:1] != 15'd0) ? PH_CS_HI : PH_CMP_HI;
               end
               PH_CS_LEN_HI, PH_CMP_HI, PH_EXT_LEN_HI, PH_CODE_HI, PH_SIZE_HI,
               PH_BODY_LEN_HI, PH_SN_LEN_HI, PH_KS_GROUP_HI, PH_KS_KLEN_HI: begin
                  hold_in  = in_byte;
                  phase_in = phase_type'(phase_ff + 5'd1);
               end
               PH_CMP_LO: begin
                  if (word != COMPRESSION_NULL) begin
                     fin = 1'b1; fst = ST_COMPRESS; stop = 1'b1;
                  end else phase_in = PH_EXT_LEN_HI;
               end
               PH_EXT_LEN_LO: begin
                  ext_in = word;
                  stop   = 1'b1;
                  if (word != msg_in) begin
                     fin = 1'b1; fst = ST_LENGTH;
                  end else if (word == 16'd0) fin = 1'b1;
                  else phase_in = PH_CODE_HI;
               end
               PH_CODE_LO: begin
                  code_in = word;
                  if (!known) begin
                     fin = 1'b1; fst = ST_UNKNOWN; stop = 1'b1;
                  end else phase_in = PH_SIZE_HI;
               end
               PH_SIZE_LO: begin
                  if (word > ext_in) begin
                     fin = 1'b1; fst = ST_LENGTH; stop = 1'b1;
                  end else begin
                     fld_in = word;
                     if (word == 16'd0) begin
                        stop = 1'b1;
                        if (ext_in == 16'd0) fin = 1'b1;
                        else phase_in = PH_CODE_HI;
                     end else begin
                        phase_in = (code_ff == EXT_PSK_MODES || code_ff == EXT_VERSIONS) ?
                                   PH_BODY_LEN1 : PH_BODY_LEN_HI;
                     end
                  end
               end
               PH_BODY_LEN_LO: begin
                  pos_in = '0;
                  if (code_ff == EXT_SERVER_NAME) phase_in = PH_SN_TYPE;
                  else if (code_ff == EXT_KEY_SHARE) begin
                     ks_in    = word;
                     phase_in = (word != 16'd0) ? PH_KS_GROUP_HI : PH_SKIP;
                  end else begin
                     ileft_in = {word[15:1], 1'b0};
                     phase_in = (word[15:1] != 15'd0) ? PH_PAIR_HI : PH_SKIP;
                  end
               end
               PH_BODY_LEN1: begin
                  pos_in = '0;
                  if (code_ff == EXT_PSK_MODES) begin
                     ileft_in = {8'd0, in_byte};
                     phase_in = (in_byte != 8'd0) ? PH_BODY_BYTE : PH_SKIP;
                  end else begin
                     ileft_in = {8'd0, in_byte[7:1], 1'b0};
                     phase_in = (in_byte[7:1] != 7'd0) ? PH_PAIR_HI : PH_SKIP;
                  end
               end
               PH_SN_TYPE: phase_in = PH_SN_LEN_HI;
               PH_SN_LEN_LO: begin
                  ileft_in = word;
                  pos_in   = '0;
                  phase_in = (word != 16'd0) ? PH_BODY_BYTE : PH_SKIP;
               end
               PH_BODY_BYTE: begin
                  q_event.data_valid = 1'b1;
                  q_event.kind  = (code_ff == EXT_SERVER_NAME) ? KIND_NAME : KIND_PSK;
                  q_event.value = {8'd0, in_byte};
                  q_event.index = pos_ff;
                  pos_in   = pos_ff + 16'd1;
                  ileft_in = ileft_ff - 16'd1;
                  if (ileft_ff == 16'd1) phase_in = PH_SKIP;
               end
               PH_PAIR_HI: begin
                  hold_in  = in_byte;
                  ileft_in = ileft_ff - 16'd1;
                  phase_in = PH_PAIR_LO;
               end
               PH_PAIR_LO: begin
                  q_event.data_valid = 1'b1;
                  q_event.kind  = (code_ff == EXT_GROUPS) ? KIND_GROUP :
                                  ((code_ff == EXT_SIGALGS) ? KIND_SIGALG : KIND_VERSION);
                  q_event.value = word;
                  q_event.index = pos_ff;
                  pos_in   = pos_ff + 16'd1;
                  ileft_in = ileft_ff - 16'd1;
                  phase_in = (ileft_ff != 16'd1) ? PH_PAIR_HI : PH_SKIP;
               end
               PH_KS_GROUP_LO: begin
                  want_in = !taken_ff;
                  if (!taken_ff) begin
                     q_event.data_valid = 1'b1;
                     q_event.kind  = KIND_KSGROUP;
                     q_event.value = word;
                  end
                  taken_in = 1'b1;
                  phase_in = PH_KS_KLEN_HI;
               end
               PH_KS_KLEN_LO: begin
                  ileft_in = word;
                  pos_in   = '0;
                  if (word == 16'd0) phase_in = PH_KS_GROUP_HI;
                  else phase_in = want_ff ? PH_KS_KEY : PH_KS_KEYSKIP;
               end
               PH_KS_KEY, PH_KS_KEYSKIP: begin
                  if (phase_ff == PH_KS_KEY) begin
                     q_event.data_valid = 1'b1;
                     q_event.kind  = KIND_PUBKEY;
                     q_event.value = {8'd0, in_byte};
                     q_event.index = pos_ff;
                     pos_in = pos_ff + 16'd1;
                  end
                  ileft_in = ileft_ff - 16'd1;
                  if (ileft_ff == 16'd1) phase_in = PH_KS_GROUP_HI;
               end
               default: ;
            endcase

            // trailing checks on the updated counters
            if (!stop) begin
               if (phase_ff >= PH_CODE_HI && phase_ff <= PH_SIZE_HI && ext_in == 16'd0) begin
                  fin = 1'b1; fst = ST_LENGTH;
               end else begin
                  if (phase_ff >= PH_KS_GROUP_HI && phase_ff <= PH_KS_KEYSKIP &&
                      ks_in == 16'd0) phase_in = PH_SKIP;
                  if (phase_ff >= PH_BODY_LEN_HI && fld_in == 16'd0) begin
                     if (ext_in == 16'd0) fin = 1'b1;
                     else phase_in = PH_CODE_HI;
                  end
               end
            end
         end

         if (!fin && in_last) begin
            fin = 1'b1; fst = ST_TRUNC;
         end
         if (fin) begin
            q_event.end_valid = 1'b1;
            q_event.status    = fst;
            done_in           = 1'b1;
         end
      end

      // re-arm on the final byte
      if (in_last) begin
         phase_in = PH_PRE;
         msg_in   = '0;
         ext_in   = '0;
         fld_in   = '0;
         ks_in    = '0;
         hold_in  = '0;
         code_in  = '0;
         pos_in   = '0;
         taken_in = 1'b0;
         done_in  = 1'b0;
         ileft_in = '0;
         want_in  = 1'b0;
      end
   end

   assign q_push = fire && (q_event.data_valid || q_event.end_valid);

endmodule

// ===== rtl/chp_queue.sv =====
`timescale 1ns / 1ps
module chp_queue
   import chp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  event_type push_data,
   output logic      can_push,
   output logic      pop_valid,
   output event_type pop_data,
   input  logic      pop
);

   event_type   mem_ff [2];
   logic        wr_ff, rd_ff;
   logic [1:0]  cnt_ff;

   assign can_push  = (cnt_ff != 2'd2) || pop;
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

// ===== rtl/chp_back.sv =====
`timescale 1ns / 1ps
module chp_back
   import chp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      ev_valid,
   input  event_type ev,
   output logic      ev_pop,
   output logic      out_valid,
   output rsp_type   out_data,
   input  logic      out_ready
);

   // emit the data half first, then the end half
   logic    data_done_ff, data_done_in;
   logic    send_data, send_end;
   logic    ovalid_ff;
   rsp_type odata_ff, odata_in;
   logic    load;

   assign send_data = ev_valid && ev.data_valid && !data_done_ff;
   assign send_end  = ev_valid && !send_data && ev.end_valid;
   assign load      = (send_data || send_end) && (!ovalid_ff || out_ready);
   assign ev_pop    = load && (send_end || !ev.end_valid);

   always_comb begin
      data_done_in = data_done_ff;
      if (load) data_done_in = send_data && ev.end_valid;
      if (send_data) begin
         odata_in = '{ev.kind, ev.value, ev.index, ST_OK, 1'b0};
      end else begin
         odata_in = '{KIND_END, 16'd0, 16'd0, ev.status, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff    <= 1'b0;
         data_done_ff <= 1'b0;
      end else begin
         data_done_ff <= data_done_in;
         if (load) ovalid_ff <= 1'b1;
         else if (out_ready) ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) odata_ff <= odata_in;
   end

   assign out_valid = ovalid_ff;
   assign out_data  = odata_ff;

endmodule

// ===== rtl/client_hello_field_parser_unit.sv =====
`timescale 1ns / 1ps
// ClientHello field parser: message bytes in, tagged items out. A byte's items pass
// through the two-entry queue between parser and emitter, then the output register.
// Throughput: one byte per cycle while the queue has room; a byte that yields a data item
// and the end item is sent as two output items, a stall that the queue absorbs.
// Reset: synchronous, active high; parser returns to expect-handshake-header state.
module client_hello_field_parser_unit
   import chp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   chp_req_if.sink   req,
   chp_rsp_if.source rsp
);

   logic      q_ready, q_push, q_valid, q_pop;
   event_type q_in, q_out;
   rsp_type   rsp_data;

   chp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .in_byte  (req.data_byte),
      .in_last  (req.last_byte),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_event  (q_in)
   );

   chp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .can_push  (q_ready),
      .pop_valid (q_valid),
      .pop_data  (q_out),
      .pop       (q_pop)
   );

   chp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ev_valid  (q_valid),
      .ev        (q_out),
      .ev_pop    (q_pop),
      .out_valid (rsp.valid),
      .out_data  (rsp_data),
      .out_ready (rsp.ready)
   );

   assign rsp.item_kind      = rsp_data.item_kind;
   assign rsp.item_value     = rsp_data.item_value;
   assign rsp.item_index     = rsp_data.item_index;
   assign rsp.parse_status   = rsp_data.parse_status;
   assign rsp.end_of_message = rsp_data.end_of_message;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import chp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   chp_req_if req_ch ();
   chp_rsp_if rsp_ch ();

   client_hello_field_parser_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       typed;
      logic [2:0] status;
   } row_type;

   // directed rows; typed rows expect an end transaction with the given status
   row_type script [15] = '{
      '{8'h01, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h26, 1'b0, 1'b0, ST_OK},
      '{8'h03, 1'b0, 1'b0, ST_OK},
      '{8'h04, 1'b0, 1'b1, ST_VERSION},
      '{8'hff, 1'b1, 1'b0, ST_OK},
      '{8'h01, 1'b1, 1'b1, ST_TRUNC},
      '{8'hff, 1'b0, 1'b0, ST_OK},
      '{8'hff, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b1, ST_LENGTH},
      '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'hff, 1'b1, 1'b0, ST_OK}
   };

   // parser shadow state
   phase_type   phase;
   logic [15:0] msg_left, ext_left, fld_left, ks_left, ext_code, pos, inner_left;
   logic [7:0]  hold;
   logic        ks_taken, done, key_first;

   rsp_type items_due[$];
   rsp_type step_items[$];
   logic [7:0] msg[$];
   int fails = 0;
   int sent = 0;
   logic quiet = 1'b0;

   function automatic void clear_parser();
      phase = PH_PRE;
      msg_left = '0; ext_left = '0; fld_left = '0; ks_left = '0; ext_code = '0;
      pos = '0; inner_left = '0; hold = '0;
      ks_taken = 1'b0; done = 1'b0; key_first = 1'b0;
   endfunction

   function automatic void put_item(logic [3:0] k, logic [15:0] v, logic [15:0] i,
                                    logic [2:0] s, logic e);
      rsp_type r;
      r.item_kind = k; r.item_value = v; r.item_index = i;
      r.parse_status = s; r.end_of_message = e;
      if (step_items.size() < 2) step_items.push_back(r);
   endfunction

   function automatic void finish_msg(logic [2:0] s);
      put_item(KIND_END, 16'd0, 16'd0, s, 1'b1);
      done = 1'b1;
   endfunction

   function automatic void next_ext();
      if (ext_left == 16'd0) finish_msg(ST_OK);
      else phase = PH_CODE_HI;
   endfunction

   function automatic logic known_ext(logic [15:0] c);
      return c == EXT_SERVER_NAME || c == EXT_GROUPS || c == EXT_SIGALGS ||
             c == EXT_VERSIONS || c == EXT_PSK_MODES || c == EXT_KEY_SHARE;
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      phase_type   ph;
      logic [15:0] word;
      ph = phase;
      word = {hold, b};
      if (ph != PH_PRE || pos >= HEADER_BYTES) begin
         if (msg_left == 16'd0) begin
            finish_msg(ST_LENGTH);
            return;
         end
         msg_left = msg_left - 16'd1;
      end
      if (ph >= PH_CODE_HI) ext_left = ext_left - 16'd1;
      if (ph >= PH_BODY_LEN_HI) fld_left = fld_left - 16'd1;
      if (ph >= PH_KS_GROUP_HI && ph <= PH_KS_KEYSKIP) ks_left = ks_left - 16'd1;

      case (ph)
         PH_PRE: begin
            if (pos == 16'd2 || pos == 16'd4) hold = b;
            else if (pos == 16'd3) msg_left = word;
            else if (pos == 16'd5 && word != LEGACY_VERSION) begin
               finish_msg(ST_VERSION);
               return;
            end
            if (pos == RANDOM_LAST) phase = PH_SID_LEN;
            pos = pos + 16'd1;
         end
         PH_SID_LEN: begin
            fld_left = {8'd0, b};
            pos = '0;
            phase = (b != 8'd0) ? PH_SID_BYTES : PH_CS_LEN_HI;
         end
         PH_SID_BYTES: begin
            put_item(KIND_SID, {8'd0, b}, pos, ST_OK, 1'b0);
            pos = pos + 16'd1;
            fld_left = fld_left - 16'd1;
            if (fld_left == 16'd0) phase = PH_CS_LEN_HI;
         end
         PH_CS_HI: begin
            fld_left = fld_left - 16'd1;
            hold = b;
            phase = PH_CS_LO;
         end
         PH_CS_LO: begin
            fld_left = fld_left - 16'd1;
            put_item(KIND_CIPHER, word, pos, ST_OK, 1'b0);
            pos = pos + 16'd1;
            phase = (fld_left != 16'd0) ? PH_CS_HI : PH_CMP_HI;
         end
         PH_CS_LEN_LO: begin
            fld_left = word & 16'hfffe;
            pos = '0;
            phase = (fld_left != 16'd0) ? PH_CS_HI : PH_CMP_HI;
         end
         PH_CS_LEN_HI, PH_CMP_HI, PH_EXT_LEN_HI, PH_CODE_HI, PH_SIZE_HI,
         PH_BODY_LEN_HI, PH_SN_LEN_HI, PH_KS_GROUP_HI, PH_KS_KLEN_HI: begin
            hold = b;
            phase = phase_type'(ph + 5'd1);
         end
         PH_CMP_LO: begin
            if (word != COMPRESSION_NULL) begin
               finish_msg(ST_COMPRESS);
               return;
            end
            phase = PH_EXT_LEN_HI;
         end
         PH_EXT_LEN_LO: begin
            ext_left = word;
            if (word != msg_left) finish_msg(ST_LENGTH);
            else next_ext();
            return;
         end
         PH_CODE_LO: begin
            ext_code = word;
            if (!known_ext(word)) begin
               finish_msg(ST_UNKNOWN);
               return;
            end
            phase = PH_SIZE_HI;
         end
         PH_SIZE_LO: begin
            if (word > ext_left) begin
               finish_msg(ST_LENGTH);
               return;
            end
            fld_left = word;
            if (word == 16'd0) begin
               next_ext();
               return;
            end
            phase = (ext_code == EXT_PSK_MODES || ext_code == EXT_VERSIONS)
                    ? PH_BODY_LEN1 : PH_BODY_LEN_HI;
         end
         PH_BODY_LEN_LO: begin
            pos = '0;
            if (ext_code == EXT_SERVER_NAME) phase = PH_SN_TYPE;
            else if (ext_code == EXT_KEY_SHARE) begin
               ks_left = word;
               phase = (word != 16'd0) ? PH_KS_GROUP_HI : PH_SKIP;
            end else begin
               inner_left = word & 16'hfffe;
               phase = (inner_left != 16'd0) ? PH_PAIR_HI : PH_SKIP;
            end
         end
         PH_BODY_LEN1: begin
            pos = '0;
            if (ext_code == EXT_PSK_MODES) begin
               inner_left = {8'd0, b};
               phase = (inner_left != 16'd0) ? PH_BODY_BYTE : PH_SKIP;
            end else begin
               inner_left = {8'd0, b & 8'hfe};
               phase = (inner_left != 16'd0) ? PH_PAIR_HI : PH_SKIP;
            end
         end
         PH_SN_TYPE: phase = PH_SN_LEN_HI;
         PH_SN_LEN_LO: begin
            inner_left = word;
            pos = '0;
            phase = (word != 16'd0) ? PH_BODY_BYTE : PH_SKIP;
         end
         PH_BODY_BYTE: begin
            put_item((ext_code == EXT_SERVER_NAME) ? KIND_NAME : KIND_PSK, {8'd0, b}, pos,
                     ST_OK, 1'b0);
            pos = pos + 16'd1;
            inner_left = inner_left - 16'd1;
            if (inner_left == 16'd0) phase = PH_SKIP;
         end
         PH_PAIR_HI: begin
            hold = b;
            inner_left = inner_left - 16'd1;
            phase = PH_PAIR_LO;
         end
         PH_PAIR_LO: begin
            put_item((ext_code == EXT_GROUPS) ? KIND_GROUP :
                     ((ext_code == EXT_SIGALGS) ? KIND_SIGALG : KIND_VERSION),
                     word, pos, ST_OK, 1'b0);
            pos = pos + 16'd1;
            inner_left = inner_left - 16'd1;
            phase = (inner_left != 16'd0) ? PH_PAIR_HI : PH_SKIP;
         end
         PH_KS_GROUP_LO: begin
            key_first = !ks_taken;
            if (key_first) put_item(KIND_KSGROUP, word, 16'd0, ST_OK, 1'b0);
            ks_taken = 1'b1;
            phase = PH_KS_KLEN_HI;
         end
         PH_KS_KLEN_LO: begin
            inner_left = word;
            pos = '0;
            if (word == 16'd0) phase = PH_KS_GROUP_HI;
            else phase = key_first ? PH_KS_KEY : PH_KS_KEYSKIP;
         end
         PH_KS_KEY, PH_KS_KEYSKIP: begin
            if (ph == PH_KS_KEY) begin
               put_item(KIND_PUBKEY, {8'd0, b}, pos, ST_OK, 1'b0);
               pos = pos + 16'd1;
            end
            inner_left = inner_left - 16'd1;
            if (inner_left == 16'd0) phase = PH_KS_GROUP_HI;
         end
         default: ;
      endcase

      if (ph >= PH_CODE_HI && ph <= PH_SIZE_HI && ext_left == 16'd0) begin
         finish_msg(ST_LENGTH);
         return;
      end
      if (ph >= PH_KS_GROUP_HI && ph <= PH_KS_KEYSKIP && ks_left == 16'd0) phase = PH_SKIP;
      if (ph >= PH_BODY_LEN_HI && fld_left == 16'd0) next_ext();
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic last);
      step_items.delete();
      if (done) begin
         if (last) clear_parser();
         return;
      end
      parse_byte(b);
      if (!done && last) finish_msg(ST_TRUNC);
      if (done && last) clear_parser();
   endfunction

   task automatic send_byte(logic [7:0] b, logic last);
      while (!quiet && $urandom_range(99) < 35) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
      quiet = (sent >= 700 && sent < 1000);
   endtask

   function automatic void put8(int v);
      msg.push_back(v[7:0]);
   endfunction

   function automatic void put16(int v);
      msg.push_back(v[15:8]);
      msg.push_back(v[7:0]);
   endfunction

   function automatic void patch16(int at, int v);
      msg[at] = v[15:8];
      msg[at + 1] = v[7:0];
   endfunction

   function automatic void put_random(int n);
      for (int i = 0; i < n; i++) put8($urandom_range(255));
   endfunction

   // well-formed hello with random content; some get broken afterwards
   function automatic void build_hello();
      logic [15:0] codes [6] = '{EXT_SERVER_NAME, EXT_GROUPS, EXT_SIGALGS,
                                 EXT_VERSIONS, EXT_PSK_MODES, EXT_KEY_SHARE};
      int n, ext_at, size_at, list_at, code, cut;
      msg.delete();
      put8($urandom_range(255));
      put8($urandom_range(255));
      put16(0);
      put16(int'(LEGACY_VERSION));
      put_random(32);
      n = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(32);
      put8(n);
      put_random(n);
      n = 2 * $urandom_range(1, 4) + (($urandom_range(9) == 0) ? 1 : 0);
      put16(n);
      put_random(n);
      put16(int'(COMPRESSION_NULL));
      ext_at = msg.size();
      put16(0);
      n = $urandom_range(0, 6);
      for (int e = 0; e < n; e++) begin
         code = int'(codes[$urandom_range(5)]);
         put16(code);
         size_at = msg.size();
         put16(0);
         list_at = msg.size();
         case (code[15:0])
            EXT_SERVER_NAME: begin
               cut = $urandom_range(0, 8);
               put16(cut + 3);
               put8(0);
               put16(cut);
               put_random(cut);
            end
            EXT_PSK_MODES: begin
               cut = $urandom_range(0, 3);
               put8(cut);
               put_random(cut);
            end
            EXT_VERSIONS: begin
               cut = 2 * $urandom_range(0, 3) + (($urandom_range(7) == 0) ? 1 : 0);
               put8(cut);
               put_random(cut);
            end
            EXT_KEY_SHARE: begin
               put16(0);
               for (int k = $urandom_range(1, 3); k > 0; k--) begin
                  cut = $urandom_range(0, 6);
                  put_random(2);
                  put16(cut);
                  put_random(cut);
               end
               patch16(list_at, msg.size() - list_at - 2);
            end
            default: begin
               cut = 2 * $urandom_range(0, 4) + (($urandom_range(7) == 0) ? 1 : 0);
               put16(cut);
               put_random(cut);
            end
         endcase
         if ($urandom_range(7) == 0) put_random($urandom_range(1, 2));
         if ($urandom_range(15) == 0) msg.delete(msg.size() - 1);
         patch16(size_at, msg.size() - size_at - 2);
      end
      patch16(ext_at, msg.size() - ext_at - 2);
      patch16(2, msg.size() - 4);

      cut = $urandom_range(99);
      if (cut < 8) msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
      else if (cut < 14) begin
         for (int k = $urandom_range(1, msg.size() - 1); k > 0; k--) msg.pop_back();
      end else if (cut < 18) put_random($urandom_range(1, 4));
      else if (cut < 22) begin
         msg.delete();
         put_random($urandom_range(1, 50));
      end
   endfunction

   task automatic apply_byte(logic [7:0] b, logic last);
      send_byte(b, last);
      predict_byte(b, last);
      foreach (step_items[i]) items_due.push_back(step_items[i]);
   endtask

   initial begin
      rsp_type r;
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.last_byte = 1'b0;
      clear_parser();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_byte(script[i].data, script[i].last);
         predict_byte(script[i].data, script[i].last);
         if (script[i].typed) begin
            r.item_kind = KIND_END; r.item_value = '0; r.item_index = '0;
            r.parse_status = script[i].status; r.end_of_message = 1'b1;
            items_due.push_back(r);
         end else begin
            foreach (step_items[j]) items_due.push_back(step_items[j]);
         end
      end

      while (sent < 1965) begin
         build_hello();
         foreach (msg[i]) apply_byte(msg[i], i == msg.size() - 1);
      end
      req_ch.valid <= 1'b0;

      while (items_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fails == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (items_due.size() == 0) begin
               $error("unexpected transaction kind %0d", rsp_ch.item_kind);
               fails++;
            end else begin
               want = items_due.pop_front();
               if (rsp_ch.item_kind !== want.item_kind) begin
                  $error("item_kind exp %0d got %0d", want.item_kind, rsp_ch.item_kind);
                  fails++;
               end
               if (rsp_ch.item_value !== want.item_value) begin
                  $error("item_value exp %h got %h", want.item_value, rsp_ch.item_value);
                  fails++;
               end
               if (rsp_ch.item_index !== want.item_index) begin
                  $error("item_index exp %0d got %0d", want.item_index, rsp_ch.item_index);
                  fails++;
               end
               if (rsp_ch.parse_status !== want.parse_status) begin
                  $error("parse_status exp %0d got %0d", want.parse_status,
                         rsp_ch.parse_status);
                  fails++;
               end
               if (rsp_ch.end_of_message !== want.end_of_message) begin
                  $error("end_of_message exp %0d got %0d", want.end_of_message,
                         rsp_ch.end_of_message);
                  fails++;
               end
            end
         end
         rsp_ch.ready <= quiet || ($urandom_range(99) >= 35);
      end
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
